// ===== hw/rtl/igmc_pkg.sv =====
package igmc_pkg;

	localparam int unsigned COORD_W   = 16;
	localparam int unsigned UNSEEN_W  = 8;
	localparam int unsigned PAD_W     = 8;
	localparam int unsigned FRAC_W    = 17;
	localparam int unsigned EXT_W     = 18;
	localparam int unsigned AREA_W    = 36;
	localparam int unsigned DVS_W     = 34;
	localparam int unsigned DIV_STEPS = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = 17;

	localparam logic [FRAC_W-1:0] ONE_Q16         = 17'h10000;
	localparam logic [FRAC_W-1:0] MAX_COST_RESET  = 17'd45875;
	localparam logic [7:0]        STALE_RESET     = 8'd1;
	localparam logic [7:0]        PAD_RESET       = 8'd0;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_COST    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STALE_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EDGE_PAD    = 2'd2;

	typedef struct packed {
		logic [DVS_W-1:0]     rem;
		logic [DVS_W-1:0]     dvs;
		logic [DIV_STEPS-1:0] quo;
		logic                 zero;
		logic                 sat;
		logic                 stale;
	} div_t;

endpackage

// ===== hw/rtl/igmc_if.sv =====
interface igmc_box_if;
	logic                             valid;
	logic                             ready;
	logic [igmc_pkg::COORD_W-1:0]     trk_left;
	logic [igmc_pkg::COORD_W-1:0]     trk_top;
	logic [igmc_pkg::COORD_W-1:0]     trk_right;
	logic [igmc_pkg::COORD_W-1:0]     trk_bottom;
	logic [igmc_pkg::COORD_W-1:0]     det_left;
	logic [igmc_pkg::COORD_W-1:0]     det_top;
	logic [igmc_pkg::COORD_W-1:0]     det_right;
	logic [igmc_pkg::COORD_W-1:0]     det_bottom;
	logic [igmc_pkg::UNSEEN_W-1:0]    frames_unseen;

	modport source (
		output valid, trk_left, trk_top, trk_right, trk_bottom,
		output det_left, det_top, det_right, det_bottom, frames_unseen,
		input  ready
	);
	modport sink (
		input  valid, trk_left, trk_top, trk_right, trk_bottom,
		input  det_left, det_top, det_right, det_bottom, frames_unseen,
		output ready
	);
endinterface

interface igmc_res_if;
	logic                           valid;
	logic                           ready;
	logic [igmc_pkg::FRAC_W-1:0]    overlap;
	logic [igmc_pkg::FRAC_W-1:0]    cost;
	logic                           admissible;

	modport source (output valid, overlap, cost, admissible, input ready);
	modport sink   (input  valid, overlap, cost, admissible, output ready);
endinterface

// ===== hw/rtl/iou_gated_match_cost.sv =====
// gated iou cost for one track box and one detection box per transfer
// box: sink channel, corners in unsigned q12.4 plus the track's unseen count
// res: source channel, overlap (q0.16 iou), gated cost and admissible flag
// cfg_we/cfg_idx/cfg_data: register write port (0 max_cost, 1 stale_limit,
//   2 edge_pad, index 3 ignored); write only while the pipeline is empty
// latency: 21 cycles from box transfer to res valid (extents, products,
//   union, gating compare, 16 restoring divider stages, result register)
// throughput: one pair per cycle; each divider stage retires one quotient bit
// stall: when res is held, the whole pipeline freezes and box.ready drops in
//   the same cycle; nothing is dropped or repeated
// reset: pipeline empty, registers at 45875 / 1 / 0
module iou_gated_match_cost (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [igmc_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [igmc_pkg::CFG_DAT_W-1:0]      cfg_data,
	igmc_box_if.sink                            box,
	igmc_res_if.source                          res
);

	localparam int unsigned CW = igmc_pkg::COORD_W;
	localparam int unsigned EW = igmc_pkg::EXT_W;
	localparam int unsigned AW = igmc_pkg::AREA_W;
	localparam int unsigned DW = igmc_pkg::DVS_W;
	localparam int unsigned FW = igmc_pkg::FRAC_W;
	localparam int unsigned NS = igmc_pkg::DIV_STEPS;

	logic [FW-1:0] max_cost_q;
	logic [7:0]    stale_limit_q;
	logic [7:0]    edge_pad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_cost_q    <= igmc_pkg::MAX_COST_RESET;
			stale_limit_q <= igmc_pkg::STALE_RESET;
			edge_pad_q    <= igmc_pkg::PAD_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				igmc_pkg::REG_MAX_COST:    max_cost_q    <= cfg_data;
				igmc_pkg::REG_STALE_LIMIT: stale_limit_q <= cfg_data[7:0];
				igmc_pkg::REG_EDGE_PAD:    edge_pad_q    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	logic adv;
	assign adv       = !res.valid || res.ready;
	assign box.ready = adv;

	// stage 1: padded extents
	logic [CW-1:0] mn_r, mx_l, mn_b, mx_t;
	logic [EW-1:0] pad_x, iw, ih, wt, ht, wd, hd;

	always_comb begin
		mn_r  = (box.trk_right  < box.det_right)  ? box.trk_right  : box.det_right;
		mx_l  = (box.trk_left   > box.det_left)   ? box.trk_left   : box.det_left;
		mn_b  = (box.trk_bottom < box.det_bottom) ? box.trk_bottom : box.det_bottom;
		mx_t  = (box.trk_top    > box.det_top)    ? box.trk_top    : box.det_top;
		pad_x = {{(EW-8){1'b0}}, edge_pad_q};
		iw    = {2'b00, mn_r} - {2'b00, mx_l} + pad_x;
		ih    = {2'b00, mn_b} - {2'b00, mx_t} + pad_x;
		wt    = {2'b00, box.trk_right}  - {2'b00, box.trk_left} + pad_x;
		ht    = {2'b00, box.trk_bottom} - {2'b00, box.trk_top}  + pad_x;
		wd    = {2'b00, box.det_right}  - {2'b00, box.det_left} + pad_x;
		hd    = {2'b00, box.det_bottom} - {2'b00, box.det_top}  + pad_x;
	end

	logic          vld_s1, vld_s2, vld_s3;
	logic [EW-1:0] iw_s1, ih_s1, wt_s1, ht_s1, wd_s1, hd_s1;
	logic          zero_s1, stale_s1;

	// stage 2: areas
	logic [DW-1:0]        inter_s2;
	logic signed [AW-1:0] area_t_s2, area_d_s2;
	logic                 zero_s2, stale_s2;

	// stage 3: union
	logic [DW-1:0]        inter_s3;
	logic signed [AW-1:0] uni_s3;
	logic                 zero_s3, stale_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= box.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			iw_s1    <= iw;
			ih_s1    <= ih;
			wt_s1    <= wt;
			ht_s1    <= ht;
			wd_s1    <= wd;
			hd_s1    <= hd;
			zero_s1  <= iw[EW-1] || (iw == '0) || ih[EW-1] || (ih == '0);
			stale_s1 <= box.frames_unseen > stale_limit_q;

			inter_s2  <= {{(DW-EW+1){1'b0}}, iw_s1[EW-2:0]} *
				{{(DW-EW+1){1'b0}}, ih_s1[EW-2:0]};
			area_t_s2 <= $signed(wt_s1) * $signed(ht_s1);
			area_d_s2 <= $signed(wd_s1) * $signed(hd_s1);
			zero_s2   <= zero_s1;
			stale_s2  <= stale_s1;

			inter_s3 <= inter_s2;
			uni_s3   <= area_t_s2 + area_d_s2 - $signed({{(AW-DW){1'b0}}, inter_s2});
			zero_s3  <= zero_s2;
			stale_s3 <= stale_s2;
		end
	end

	// stage 4 loads the divider, stages 5 to 20 retire one quotient bit each
	igmc_pkg::div_t dv_s     [NS+1];
	logic           dv_vld_s [NS+1];
	igmc_pkg::div_t dv_init;

	always_comb begin
		dv_init.rem   = inter_s3;
		dv_init.dvs   = uni_s3[DW-1:0];
		dv_init.quo   = '0;
		dv_init.zero  = zero_s3;
		dv_init.sat   = (uni_s3 <= 0) || ($signed({{(AW-DW){1'b0}}, inter_s3}) >= uni_s3);
		dv_init.stale = stale_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld_s[0] <= 1'b0;
		end else if (adv) begin
			dv_vld_s[0] <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_s[0] <= dv_init;
		end
	end

	for (genvar k = 0; k < NS; k++) begin : g_div
		igmc_pkg::div_t nxt;
		logic [DW+1:0]  diff;

		always_comb begin
			nxt  = dv_s[k];
			diff = {1'b0, dv_s[k].rem, 1'b0} - {2'b00, dv_s[k].dvs};
			if (!diff[DW+1]) begin
				nxt.rem = diff[DW-1:0];
				nxt.quo = {dv_s[k].quo[NS-2:0], 1'b1};
			end else begin
				nxt.rem = {dv_s[k].rem[DW-2:0], 1'b0};
				nxt.quo = {dv_s[k].quo[NS-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[k+1] <= 1'b0;
			end else if (adv) begin
				dv_vld_s[k+1] <= dv_vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_s[k+1] <= nxt;
			end
		end
	end

	// result register: select iou, gate cost
	logic [FW-1:0] ovl, lim, cst;
	logic          ok;

	always_comb begin
		if (dv_s[NS].zero) begin
			ovl = '0;
		end else if (dv_s[NS].sat) begin
			ovl = igmc_pkg::ONE_Q16;
		end else begin
			ovl = {1'b0, dv_s[NS].quo};
		end
		lim = (max_cost_q > igmc_pkg::ONE_Q16) ? igmc_pkg::ONE_Q16 : max_cost_q;
		cst = igmc_pkg::ONE_Q16 - ovl;
		ok  = 1'b1;
		if (dv_s[NS].stale || (cst > lim)) begin
			cst = lim + FW'(1);
			ok  = 1'b0;
		end
	end

	logic          res_vld_q;
	logic [FW-1:0] res_ovl_q, res_cost_q;
	logic          res_ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (adv) begin
			res_vld_q <= dv_vld_s[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_ovl_q  <= ovl;
			res_cost_q <= cst;
			res_ok_q   <= ok;
		end
	end

	assign res.valid      = res_vld_q;
	assign res.overlap    = res_ovl_q;
	assign res.cost       = res_cost_q;
	assign res.admissible = res_ok_q;

	a_ok_cost : assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.admissible |-> res.cost == igmc_pkg::ONE_Q16 - res.overlap)
		else $error("admissible cost is not one minus overlap");

	a_gated_cost : assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.admissible |-> res.cost == lim + FW'(1))
		else $error("gated cost is not limit plus one");

	a_ovl_range : assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.overlap <= igmc_pkg::ONE_Q16)
		else $error("overlap above one");

	a_stall : assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |-> !box.ready)
		else $error("input taken while result stalled");

endmodule

// ===== tb/iou_gated_match_cost_test.sv =====
module iou_gated_match_cost_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [igmc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int unsigned PIPE_DEPTH   = 21;
	localparam int unsigned QUIET_LIMIT  = 4000;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned PHASE_PAIRS  = 90;
	localparam int unsigned IDLE_PCT     = 28;

	typedef struct packed {
		logic [igmc_pkg::COORD_W-1:0]  trk_left;
		logic [igmc_pkg::COORD_W-1:0]  trk_top;
		logic [igmc_pkg::COORD_W-1:0]  trk_right;
		logic [igmc_pkg::COORD_W-1:0]  trk_bottom;
		logic [igmc_pkg::COORD_W-1:0]  det_left;
		logic [igmc_pkg::COORD_W-1:0]  det_top;
		logic [igmc_pkg::COORD_W-1:0]  det_right;
		logic [igmc_pkg::COORD_W-1:0]  det_bottom;
		logic [igmc_pkg::UNSEEN_W-1:0] frames_unseen;
	} box_pair_t;

	typedef struct packed {
		logic [igmc_pkg::FRAC_W-1:0] overlap;
		logic [igmc_pkg::FRAC_W-1:0] cost;
		logic                        admissible;
	} gated_cost_t;

	class cost_board;
		logic [igmc_pkg::FRAC_W-1:0] max_cost;
		logic [7:0]                  stale_limit;
		logic [7:0]                  edge_pad;
		gated_cost_t                 costs_due[$];
		int unsigned                 errors;

		function new();
			max_cost = igmc_pkg::MAX_COST_RESET;
			stale_limit = igmc_pkg::STALE_RESET;
			edge_pad = igmc_pkg::PAD_RESET;
			errors = 0;
		endfunction

		function void write_reg(logic [igmc_pkg::CFG_IDX_W-1:0] idx,
				logic [igmc_pkg::CFG_DAT_W-1:0] data);
			case (idx)
				igmc_pkg::REG_MAX_COST: max_cost = data[igmc_pkg::FRAC_W-1:0];
				igmc_pkg::REG_STALE_LIMIT: stale_limit = data[7:0];
				igmc_pkg::REG_EDGE_PAD: edge_pad = data[7:0];
				default: ;
			endcase
		endfunction

		function logic [igmc_pkg::FRAC_W-1:0] iou_of(box_pair_t b);
			longint pad, tl, tt, tr, tb, dl, dt, dr, db;
			longint iw, ih, inter, area_t, area_d, uni, q;
			pad = edge_pad;
			tl = b.trk_left;
			tt = b.trk_top;
			tr = b.trk_right;
			tb = b.trk_bottom;
			dl = b.det_left;
			dt = b.det_top;
			dr = b.det_right;
			db = b.det_bottom;
			iw = ((tr < dr) ? tr : dr) - ((tl > dl) ? tl : dl) + pad;
			if (iw <= 0)
				return '0;
			ih = ((tb < db) ? tb : db) - ((tt > dt) ? tt : dt) + pad;
			if (ih <= 0)
				return '0;
			inter = iw * ih;
			area_t = (tr - tl + pad) * (tb - tt + pad);
			area_d = (dr - dl + pad) * (db - dt + pad);
			uni = area_t + area_d - inter;
			if (uni <= 0 || inter >= uni)
				return igmc_pkg::ONE_Q16;
			q = (inter * 65536) / uni;
			return q[igmc_pkg::FRAC_W-1:0];
		endfunction

		function void note_pair(box_pair_t b);
			gated_cost_t                 e;
			logic [igmc_pkg::FRAC_W-1:0] lim;
			lim = (max_cost > igmc_pkg::ONE_Q16) ? igmc_pkg::ONE_Q16 : max_cost;
			e.overlap = iou_of(b);
			e.cost = igmc_pkg::ONE_Q16 - e.overlap;
			e.admissible = 1'b1;
			if (b.frames_unseen > stale_limit || e.cost > lim) begin
				e.cost = lim + 17'd1;
				e.admissible = 1'b0;
			end
			costs_due = {costs_due, e};
		endfunction

		function void check_cost(logic [igmc_pkg::FRAC_W-1:0] overlap,
				logic [igmc_pkg::FRAC_W-1:0] cost, logic admissible);
			gated_cost_t e;
			if (costs_due.size() == 0) begin
				$error("unexpected result: overlap %0d cost %0d admissible %0d",
					overlap, cost, admissible);
				errors++;
				return;
			end
			e = costs_due.pop_front();
			if (overlap !== e.overlap) begin
				$error("overlap: expected %0d, got %0d", e.overlap, overlap);
				errors++;
			end
			if (cost !== e.cost) begin
				$error("cost: expected %0d, got %0d", e.cost, cost);
				errors++;
			end
			if (admissible !== e.admissible) begin
				$error("admissible: expected %0d, got %0d", e.admissible, admissible);
				errors++;
			end
		endfunction

		function int unsigned pending();
			return costs_due.size();
		endfunction
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_we;
	logic [igmc_pkg::CFG_IDX_W-1:0]  cfg_idx;
	logic [igmc_pkg::CFG_DAT_W-1:0]  cfg_data;
	int unsigned                     src_idle_pct;
	int unsigned                     sink_idle_pct;
	bit                              sink_hold;
	int unsigned                     quiet_cycles;
	cost_board                       board;

	igmc_box_if box_ch();
	igmc_res_if res_ch();

	iou_gated_match_cost u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.box      (box_ch),
		.res      (res_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// transfer monitors and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (box_ch.valid && box_ch.ready)
				board.note_pair(box_pair_t'{box_ch.trk_left, box_ch.trk_top,
					box_ch.trk_right, box_ch.trk_bottom, box_ch.det_left, box_ch.det_top,
					box_ch.det_right, box_ch.det_bottom, box_ch.frames_unseen});
			if (res_ch.valid && res_ch.ready)
				board.check_cost(res_ch.overlap, res_ch.cost, res_ch.admissible);
			if ((box_ch.valid && box_ch.ready) || (res_ch.valid && res_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// result receiver, with one long hold-off on request
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (sink_hold) begin
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				sink_hold = 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	function automatic logic [igmc_pkg::COORD_W-1:0] clip16(int v);
		if (v < 0)
			return '0;
		if (v > 65535)
			return 16'hFFFF;
		return v[igmc_pkg::COORD_W-1:0];
	endfunction

	function automatic box_pair_t mk(int tl, int tt, int tr, int tb,
			int dl, int dt, int dr, int db, int fu);
		box_pair_t b;
		b = '{clip16(tl), clip16(tt), clip16(tr), clip16(tb),
			clip16(dl), clip16(dt), clip16(dr), clip16(db), fu[igmc_pkg::UNSEEN_W-1:0]};
		return b;
	endfunction

	function automatic box_pair_t rand_pair();
		int           kind, x, y, w, h, dx, dy, dw, dh;
		logic [159:0] raw;
		box_pair_t    b;
		kind = $urandom_range(99);
		x = $urandom_range(65535);
		y = $urandom_range(65535);
		w = ($urandom_range(9) == 0) ? $urandom_range(20000) : $urandom_range(400);
		h = ($urandom_range(9) == 0) ? $urandom_range(20000) : $urandom_range(400);
		dx = int'($urandom_range(2 * w + 20)) - (w + 10);
		dy = int'($urandom_range(2 * h + 20)) - (h + 10);
		dw = int'($urandom_range(w / 2 + 8)) - (w / 4 + 4);
		dh = int'($urandom_range(h / 2 + 8)) - (h / 4 + 4);
		if (kind < 60) begin
			b = mk(x, y, x + w, y + h, x + dx, y + dy, x + dx + w + dw, y + dy + h + dh, 0);
		end else if (kind < 75) begin
			raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
			b = raw[$bits(box_pair_t)-1:0];
		end else if (kind < 85) begin
			// side by side, touching or a little apart
			b = mk(x, y, x + w, y + h, x + w + $urandom_range(2), y, x + 2 * w + 1, y + h, 0);
		end else if (kind < 93) begin
			b = mk(x, y, x + w, y + h, x, y, x + w, y + h, 0);
			if ($urandom_range(1))
				b = mk(x, y, x + w, y + h, x + w, y + h, x, y, 0);
		end else begin
			b = mk(x + w, y + h, x, y, x + dx, y + dy, x + dx + w, y + dy + h, 0);
		end
		b.frames_unseen = ($urandom_range(4) == 0) ? igmc_pkg::UNSEEN_W'($urandom_range(255))
			: igmc_pkg::UNSEEN_W'($urandom_range(3));
		return b;
	endfunction

	task automatic send_pair(input box_pair_t b);
		if ($urandom_range(99) < src_idle_pct) begin
			box_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		box_ch.valid <= 1'b1;
		{box_ch.trk_left, box_ch.trk_top, box_ch.trk_right, box_ch.trk_bottom,
			box_ch.det_left, box_ch.det_top, box_ch.det_right, box_ch.det_bottom,
			box_ch.frames_unseen} <= b;
		do @(posedge clk); while (!box_ch.ready);
	endtask

	task automatic drain();
		box_ch.valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	task automatic cfg_write(input logic [igmc_pkg::CFG_IDX_W-1:0] idx,
			input int unsigned data);
		cfg_idx <= idx;
		cfg_data <= data[igmc_pkg::CFG_DAT_W-1:0];
		board.write_reg(idx, data[igmc_pkg::CFG_DAT_W-1:0]);
		@(posedge clk);
	endtask

	task automatic set_regs(input int unsigned max_cost, input int unsigned stale,
			input int unsigned pad);
		cfg_we <= 1'b1;
		cfg_write(igmc_pkg::REG_MAX_COST, max_cost);
		cfg_write(igmc_pkg::REG_STALE_LIMIT, stale);
		cfg_write(igmc_pkg::REG_EDGE_PAD, pad);
		cfg_write(REG_UNUSED, $urandom);
		cfg_we <= 1'b0;
	endtask

	task automatic send_random(input int unsigned n);
		repeat (n) send_pair(rand_pair());
	endtask

	initial begin
		board = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = igmc_pkg::REG_MAX_COST;
		cfg_data = '0;
		box_ch.valid = 1'b0;
		{box_ch.trk_left, box_ch.trk_top, box_ch.trk_right, box_ch.trk_bottom,
			box_ch.det_left, box_ch.det_top, box_ch.det_right, box_ch.det_bottom,
			box_ch.frames_unseen} = '0;
		src_idle_pct = IDLE_PCT;
		sink_idle_pct = IDLE_PCT;
		sink_hold = 1'b0;
		quiet_cycles = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: max_cost 45875, stale_limit 1, no padding
		send_pair(mk(100, 100, 200, 200, 100, 100, 200, 200, 0));
		send_pair(mk(0, 0, 160, 160, 80, 0, 240, 160, 1));
		send_pair(mk(0, 0, 10, 10, 20, 20, 30, 30, 0));
		send_pair(mk(0, 0, 16, 16, 16, 0, 32, 16, 0));
		send_pair(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_pair(mk(65535, 65535, 65535, 65535, 65535, 65535, 65535, 65535, 255));
		send_pair(mk(0, 0, 65535, 65535, 1000, 1000, 1016, 1016, 0));
		send_pair(mk(5000, 5000, 5010, 5020, 0, 0, 65535, 65535, 1));
		send_pair(mk(100, 100, 200, 200, 100, 100, 200, 200, 2));
		send_pair(mk(100, 100, 200, 200, 100, 100, 200, 200, 255));
		send_pair(mk(200, 200, 100, 100, 50, 50, 250, 250, 0));
		send_pair(mk('hAAAA, 'h5555, 'hAAAB, 'h5556, 'h5555, 'hAAAA, 'hFFFF, 'hFFFF, 'hAA));
		send_pair(mk(0, 0, 1, 65535, 0, 0, 1, 65535, 0));
		send_pair(mk(0, 0, 1000, 1000, 1, 0, 1001, 1000, 0));
		send_pair(mk(0, 0, 65535, 65535, 0, 0, 65535, 65535, 0));
		send_pair(mk(0, 0, 65535, 65535, 1, 1, 65535, 65535, 1));
		drain();

		set_regs(65536, 255, 0);
		send_random(PHASE_PAIRS);
		drain();

		// zero threshold, widest padding, inverted boxes that padding does or does not revive
		set_regs(0, 0, 255);
		send_pair(mk(1000, 1000, 900, 900, 1000, 1000, 900, 900, 0));
		send_pair(mk(1000, 1000, 700, 700, 1000, 1000, 700, 700, 0));
		send_pair(mk(1000, 1000, 1100, 1100, 1050, 1050, 1000, 1000, 0));
		sink_hold = 1'b1;
		send_random(PHASE_PAIRS);
		drain();

		// threshold beyond one, no idling on either side
		src_idle_pct = 0;
		sink_idle_pct = 0;
		set_regs(17'h1FFFF, 3, 16);
		send_random(PHASE_PAIRS);
		drain();

		src_idle_pct = IDLE_PCT;
		sink_idle_pct = IDLE_PCT;
		set_regs(32768, 1, 1);
		send_random(PHASE_PAIRS);
		drain();

		set_regs($urandom_range(65536), $urandom_range(255), $urandom_range(255));
		send_random(PHASE_PAIRS);
		drain();

		repeat (PIPE_DEPTH + 4) @(posedge clk);
		if (board.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
